// File: hdl/sle_pkg.sv
// Shared types, request and status codes for the sequential list engine.
`timescale 1ns / 1ps

package sle_pkg;

    // word and field widths
    localparam int WORD_W    = 32;
    localparam int REQ_W     = 3;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 3;
    localparam int DEPTH_DEF = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOCATE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_MIN = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REVERSE = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DEL_ALL = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // request word
    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] result_value;
        logic [POS_W-1:0]         result_position;
        logic [POS_W-1:0]         new_length;
    } t_out_word;

    // compare unit flags
    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

endpackage

// File: hdl/sle_cmp.sv
// Shared compare unit: equality and signed less-than on two words.
`timescale 1ns / 1ps

module sle_cmp (
    input  logic signed [sle_pkg::WORD_W-1:0] i_a,
    input  logic signed [sle_pkg::WORD_W-1:0] i_b,
    output sle_pkg::t_cmp_res                 o_res
);

    // one compare serves locate, remove-all and minimum search
    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
    end

endmodule

// File: hdl/sequential_list_engine.sv
// Top level of the sequential list engine: sequencer, list memory and result register.
`timescale 1ns / 1ps

// The list lives in a single-port-read, single-port-write memory of DEPTH words, and
// requests walk it under a small sequencer through one read port and one shared
// compare unit. Errors, the unused code and reverse of a list of at most one entry go
// straight from the dispatch state to the result; a read fetches one word; locate stops
// at its first hit or walks the whole list; insert and delete move the entries past the
// position; remove-all, remove-minimum and reverse walk the whole list. o_ready is high
// again in the cycle after the edge that loads the result. The result is held in an
// output register, so a new request may be taken while the last result still waits for
// i_ready; if it is still waiting when the next result is ready, the final step stalls
// until i_ready. After reset the list is empty and no clearing pass is needed.
module sequential_list_engine #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  sle_pkg::t_in_word    i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output sle_pkg::t_out_word   o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = ((LW > sle_pkg::POS_W) ? LW : sle_pkg::POS_W) + 1;
    localparam int WW = sle_pkg::WORD_W;
    localparam int PW = sle_pkg::POS_W;

    // sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_INS_CHK  = 5'd2;
    localparam logic [4:0] S_INS_WR   = 5'd3;
    localparam logic [4:0] S_INS_PUT  = 5'd4;
    localparam logic [4:0] S_DEL_CAP  = 5'd5;
    localparam logic [4:0] S_DEL_CHK  = 5'd6;
    localparam logic [4:0] S_DEL_WR   = 5'd7;
    localparam logic [4:0] S_RD_CAP   = 5'd8;
    localparam logic [4:0] S_LOC_CHK  = 5'd9;
    localparam logic [4:0] S_LOC_EVAL = 5'd10;
    localparam logic [4:0] S_MIN_INIT = 5'd11;
    localparam logic [4:0] S_MIN_CHK  = 5'd12;
    localparam logic [4:0] S_MIN_EVAL = 5'd13;
    localparam logic [4:0] S_MIN_MOVE = 5'd14;
    localparam logic [4:0] S_REV_CHK  = 5'd15;
    localparam logic [4:0] S_REV_B    = 5'd16;
    localparam logic [4:0] S_REV_W1   = 5'd17;
    localparam logic [4:0] S_REV_W2   = 5'd18;
    localparam logic [4:0] S_RA_CHK   = 5'd19;
    localparam logic [4:0] S_RA_EVAL  = 5'd20;
    localparam logic [4:0] S_DONE     = 5'd21;

    // control registers
    logic [4:0]    r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic          r_ovalid, n_ovalid;

    // payload registers
    logic [sle_pkg::REQ_W-1:0]    r_req, n_req;
    logic [PW-1:0]                r_pos, n_pos;
    logic signed [WW-1:0]         r_val, n_val;
    logic [LW-1:0]                r_j, n_j;
    logic [LW-1:0]                r_k, n_k;
    logic signed [WW-1:0]         r_min, n_min;
    logic signed [WW-1:0]         r_tmp, n_tmp;
    logic [sle_pkg::STATUS_W-1:0] r_status, n_status;
    logic signed [WW-1:0]         r_rval, n_rval;
    logic [PW-1:0]                r_rpos, n_rpos;
    sle_pkg::t_out_word           r_out, n_out;

    // list memory
    logic signed [WW-1:0] r_mem [DEPTH];
    logic signed [WW-1:0] r_rdata;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_wa, mem_ra;
    logic signed [WW-1:0] mem_wd;

    // helpers
    logic [CW-1:0]        w_pos_x, w_len_x, w_j_x;
    logic [PW-1:0]        w_posm1;
    logic [LW-1:0]        w_jm1, w_jp1, w_lenm1, w_kp1, w_km1;
    logic signed [WW-1:0] w_cmp_b;
    sle_pkg::t_cmp_res    w_cmp;

    assign w_pos_x = CW'(r_pos);
    assign w_len_x = CW'(r_len);
    assign w_j_x   = CW'(r_j);
    assign w_posm1 = r_pos - PW'(1);
    assign w_jm1   = r_j - LW'(1);
    assign w_jp1   = r_j + LW'(1);
    assign w_lenm1 = r_len - LW'(1);
    assign w_kp1   = r_k + LW'(1);
    assign w_km1   = r_k - LW'(1);

    // shared compare unit
    assign w_cmp_b = (r_state == S_MIN_EVAL) ? r_min : r_val;

    sle_cmp u_cmp (
        .i_a   (r_rdata),
        .i_b   (w_cmp_b),
        .o_res (w_cmp)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_ovalid = r_ovalid && !i_ready;
        n_req    = r_req;
        n_pos    = r_pos;
        n_val    = r_val;
        n_j      = r_j;
        n_k      = r_k;
        n_min    = r_min;
        n_tmp    = r_tmp;
        n_status = r_status;
        n_rval   = r_rval;
        n_rpos   = r_rpos;
        n_out    = r_out;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_wa   = '0;
        mem_ra   = '0;
        mem_wd   = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req    = i_in.req_type;
                    n_pos    = i_in.position;
                    n_val    = i_in.value;
                    n_status = sle_pkg::ST_OK;
                    n_rval   = '0;
                    n_rpos   = '0;
                    n_state  = S_DISP;
                end
            end

            // argument checks and start of each walk
            S_DISP: begin
                n_state = S_DONE;
                case (r_req)
                    sle_pkg::REQ_INSERT: begin
                        if (r_pos == '0 || w_pos_x > w_len_x + CW'(1)) begin
                            n_status = sle_pkg::ST_BADPOS;
                        end else if (r_len == LW'(DEPTH)) begin
                            n_status = sle_pkg::ST_FULL;
                        end else begin
                            n_j     = r_len;
                            n_state = S_INS_CHK;
                        end
                    end
                    sle_pkg::REQ_DELETE, sle_pkg::REQ_READ: begin
                        if (r_pos == '0 || w_pos_x > w_len_x) begin
                            n_status = sle_pkg::ST_BADPOS;
                        end else begin
                            mem_re  = 1'b1;
                            mem_ra  = AW'(w_posm1);
                            n_j     = LW'(r_pos);
                            n_state = (r_req == sle_pkg::REQ_READ) ? S_RD_CAP : S_DEL_CAP;
                        end
                    end
                    sle_pkg::REQ_LOCATE: begin
                        n_status = sle_pkg::ST_NOTFOUND;
                        n_j      = '0;
                        n_state  = S_LOC_CHK;
                    end
                    sle_pkg::REQ_DEL_MIN: begin
                        if (r_len == '0) begin
                            n_status = sle_pkg::ST_EMPTY;
                        end else begin
                            mem_re  = 1'b1;
                            mem_ra  = '0;
                            n_state = S_MIN_INIT;
                        end
                    end
                    sle_pkg::REQ_REVERSE: begin
                        if (r_len > LW'(1)) begin
                            n_j     = '0;
                            n_k     = w_lenm1;
                            n_state = S_REV_CHK;
                        end
                    end
                    sle_pkg::REQ_DEL_ALL: begin
                        n_j     = '0;
                        n_k     = '0;
                        n_state = S_RA_CHK;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // insert: move entries up from the tail, then drop the word in
            S_INS_CHK: begin
                if (w_j_x >= w_pos_x) begin
                    mem_re  = 1'b1;
                    mem_ra  = w_jm1[AW-1:0];
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_j[AW-1:0];
                n_j     = w_jm1;
                n_state = S_INS_CHK;
            end
            S_INS_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = AW'(w_posm1);
                mem_wd  = r_val;
                n_len   = r_len + LW'(1);
                n_state = S_DONE;
            end

            // delete: keep the removed word, move later entries down
            S_DEL_CAP: begin
                n_rval  = r_rdata;
                n_state = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                if (r_j < r_len) begin
                    mem_re  = 1'b1;
                    mem_ra  = r_j[AW-1:0];
                    n_state = S_DEL_WR;
                end else begin
                    n_len   = w_lenm1;
                    n_state = S_DONE;
                end
            end
            S_DEL_WR: begin
                mem_we  = 1'b1;
                mem_wa  = w_jm1[AW-1:0];
                n_j     = w_jp1;
                n_state = S_DEL_CHK;
            end

            S_RD_CAP: begin
                n_rval  = r_rdata;
                n_state = S_DONE;
            end

            // locate: first match wins
            S_LOC_CHK: begin
                if (r_j < r_len) begin
                    mem_re  = 1'b1;
                    mem_ra  = r_j[AW-1:0];
                    n_state = S_LOC_EVAL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LOC_EVAL: begin
                if (w_cmp.eq) begin
                    n_rpos   = PW'(w_jp1);
                    n_status = sle_pkg::ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_j     = w_jp1;
                    n_state = S_LOC_CHK;
                end
            end

            // remove minimum: scan, then fill the slot with the last entry
            S_MIN_INIT: begin
                n_min   = r_rdata;
                n_k     = '0;
                n_j     = LW'(1);
                n_state = S_MIN_CHK;
            end
            S_MIN_CHK: begin
                mem_re = 1'b1;
                if (r_j < r_len) begin
                    mem_ra  = r_j[AW-1:0];
                    n_state = S_MIN_EVAL;
                end else begin
                    mem_ra  = w_lenm1[AW-1:0];
                    n_state = S_MIN_MOVE;
                end
            end
            S_MIN_EVAL: begin
                if (w_cmp.lt) begin
                    n_min = r_rdata;
                    n_k   = r_j;
                end
                n_j     = w_jp1;
                n_state = S_MIN_CHK;
            end
            S_MIN_MOVE: begin
                mem_we  = 1'b1;
                mem_wa  = r_k[AW-1:0];
                n_rval  = r_min;
                n_len   = w_lenm1;
                n_state = S_DONE;
            end

            // reverse: swap the outer pair, step inward
            S_REV_CHK: begin
                if (r_j < r_k) begin
                    mem_re  = 1'b1;
                    mem_ra  = r_j[AW-1:0];
                    n_state = S_REV_B;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REV_B: begin
                n_tmp   = r_rdata;
                mem_re  = 1'b1;
                mem_ra  = r_k[AW-1:0];
                n_state = S_REV_W1;
            end
            S_REV_W1: begin
                mem_we  = 1'b1;
                mem_wa  = r_j[AW-1:0];
                n_state = S_REV_W2;
            end
            S_REV_W2: begin
                mem_we  = 1'b1;
                mem_wa  = r_k[AW-1:0];
                mem_wd  = r_tmp;
                n_j     = w_jp1;
                n_k     = w_km1;
                n_state = S_REV_CHK;
            end

            // remove all equal: compact the survivors toward the head
            S_RA_CHK: begin
                if (r_j < r_len) begin
                    mem_re  = 1'b1;
                    mem_ra  = r_j[AW-1:0];
                    n_state = S_RA_EVAL;
                end else begin
                    n_len   = r_k;
                    n_state = S_DONE;
                end
            end
            S_RA_EVAL: begin
                if (!w_cmp.eq) begin
                    mem_we = 1'b1;
                    mem_wa = r_k[AW-1:0];
                    n_k    = w_kp1;
                end
                n_j     = w_jp1;
                n_state = S_RA_CHK;
            end

            // hand the result word to the output register once it is free
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_out.status          = r_status;
                    n_out.result_value    = r_rval;
                    n_out.result_position = r_rpos;
                    n_out.new_length      = PW'(r_len);
                    n_ovalid              = 1'b1;
                    n_state               = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_j      <= n_j;
        r_k      <= n_k;
        r_min    <= n_min;
        r_tmp    <= n_tmp;
        r_status <= n_status;
        r_rval   <= n_rval;
        r_rpos   <= n_rpos;
        r_out    <= n_out;
    end

    // list memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

endmodule

// File: tb/sle_checker.sv
// Checker for the sequential list engine: a shadow copy of the list, checks every result word.
`timescale 1ns / 1ps

module sle_checker
    import sle_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out,
    output int        o_mismatches,
    output int        o_checked,
    output int        o_rejected,
    output int        o_pending,
    output int        o_list_len
);

    localparam int CAPACITY   = DEPTH_DEF;

    // shadow copy of the list; entries at or past entry_count are never read
    logic signed [WORD_W-1:0] entries [CAPACITY];
    int                       entry_count = 0;

    // result words still owed by the block, oldest first
    t_out_word owed_results [$];

    int mismatch_count = 0;
    int checked_count  = 0;
    int rejected_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_checked    = checked_count;
    assign o_rejected   = rejected_count;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // carry out one request on the shadow list and return the result word it should give
    function automatic t_out_word apply_request(input t_in_word w);
        t_out_word                r;
        int                       pos;
        int                       k;
        int                       lo;
        int                       hi;
        int                       kept;
        int                       min_at;
        logic signed [WORD_W-1:0] held;
        r      = '0;
        r.status = ST_OK;
        pos    = int'(w.position);
        case (w.req_type)
            REQ_INSERT: begin
                // position check comes ahead of the full check
                if (pos < 1 || pos > entry_count + 1) begin
                    r.status = ST_BADPOS;
                end else if (entry_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = entry_count; k >= pos; k--)
                        entries[k] = entries[k-1];
                    entries[pos-1] = w.value;
                    entry_count++;
                end
            end
            REQ_DELETE: begin
                if (pos < 1 || pos > entry_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.result_value = entries[pos-1];
                    for (k = pos; k < entry_count; k++)
                        entries[k-1] = entries[k];
                    entry_count--;
                end
            end
            REQ_READ: begin
                if (pos < 1 || pos > entry_count)
                    r.status = ST_BADPOS;
                else
                    r.result_value = entries[pos-1];
            end
            REQ_LOCATE: begin
                // first match wins
                r.status = ST_NOTFOUND;
                for (k = 0; k < entry_count; k++) begin
                    if (r.status == ST_NOTFOUND && entries[k] == w.value) begin
                        r.status          = ST_OK;
                        r.result_position = POS_W'(k + 1);
                    end
                end
            end
            REQ_DEL_MIN: begin
                if (entry_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // lowest position wins a tie; the last entry fills the hole
                    min_at = 0;
                    for (k = 1; k < entry_count; k++)
                        if (entries[k] < entries[min_at])
                            min_at = k;
                    r.result_value  = entries[min_at];
                    entries[min_at] = entries[entry_count-1];
                    entry_count--;
                end
            end
            REQ_REVERSE: begin
                lo = 0;
                hi = entry_count - 1;
                while (lo < hi) begin
                    held        = entries[lo];
                    entries[lo] = entries[hi];
                    entries[hi] = held;
                    lo++;
                    hi--;
                end
            end
            REQ_DEL_ALL: begin
                kept = 0;
                for (k = 0; k < entry_count; k++) begin
                    if (entries[k] != w.value) begin
                        entries[kept] = entries[k];
                        kept++;
                    end
                end
                entry_count = kept;
            end
            default: begin
                // unused code: list untouched, status OK, zero value and position
            end
        endcase
        r.new_length = POS_W'(entry_count);
        return r;
    endfunction

    // watch both channels; the result side is checked before a new word is taken
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            entry_count = 0;
            owed_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result word with nothing owed (new_length)",
                                    i_out.new_length, -1);
                end else begin
                    want = owed_results.pop_front();
                    checked_count++;
                    if (i_out.status !== want.status)
                        report_mismatch("status", i_out.status, want.status);
                    if (i_out.result_value !== want.result_value)
                        report_mismatch("result_value", i_out.result_value,
                                        want.result_value);
                    if (i_out.result_position !== want.result_position)
                        report_mismatch("result_position", i_out.result_position,
                                        want.result_position);
                    if (i_out.new_length !== want.new_length)
                        report_mismatch("new_length", i_out.new_length, want.new_length);
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = apply_request(i_in);
                if (want.status != ST_OK)
                    rejected_count++;
                owed_results.push_back(want);
            end
        end
        o_pending  <= owed_results.size();
        o_list_len <= entry_count;
    end

endmodule

// File: tb/sequential_list_engine_test.sv
// Testbench top for the sequential list engine: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module sequential_list_engine_test;
    import sle_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int ITEM_TARGET  = 1850;
    localparam int MAX_GAP      = 12;
    localparam int DRAIN_CYCLES = 2 * DEPTH_DEF + 8;
    localparam int HISTORY      = 8;

    typedef enum int {ROUND_GROW, ROUND_SHRINK, ROUND_MIXED, ROUND_NOISE} t_round_kind;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_word  i_in    = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_word o_out;

    int mismatches;
    int checked;
    int rejected;
    int pending;
    int tracked_len;

    // request-side bookkeeping
    bit                       steady_feed = 1'b0;
    int                       sent_count  = 0;
    int                       op_count [8];
    logic signed [WORD_W-1:0] recent_values [HISTORY];
    int                       recent_fill = 0;
    int                       recent_slot = 0;

    sequential_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    sle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in         (i_in),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out        (o_out),
        .o_mismatches (mismatches),
        .o_checked    (checked),
        .o_rejected   (rejected),
        .o_pending    (pending),
        .o_list_len   (tracked_len)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("timeout with %0d result words still owed", pending);
        $display("sequential_list_engine_test NOT OK");
        $finish;
    end

    function automatic t_in_word make_word(input logic [REQ_W-1:0] req, input int pos,
                                           input logic signed [WORD_W-1:0] val);
        t_in_word w;
        w.req_type = req;
        w.position = POS_W'(pos);
        w.value    = val;
        return w;
    endfunction

    // values: wide random, a small cluster for duplicates and ties, extremes, recent inserts
    function automatic logic signed [WORD_W-1:0] pick_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom;
        if (pick < 7)
            return $urandom_range(0, 6) - 3;
        if (pick == 7) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        if (recent_fill > 0)
            return recent_values[$urandom_range(0, recent_fill - 1)];
        return $urandom;
    endfunction

    // len may lag the true length by one word; it only shapes the distribution
    function automatic t_in_word make_request(input t_round_kind kind, input int len);
        t_in_word    w;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (kind)
            ROUND_GROW:
                w.req_type = (roll < 70) ? REQ_INSERT
                           : REQ_W'($urandom_range(REQ_DELETE, REQ_DEL_ALL));
            ROUND_SHRINK:
                w.req_type = (roll < 25) ? REQ_DELETE
                           : (roll < 45) ? REQ_DEL_MIN
                           : (roll < 60) ? REQ_DEL_ALL
                           : (roll < 70) ? REQ_INSERT
                           : REQ_W'($urandom_range(REQ_READ, REQ_REVERSE));
            ROUND_MIXED:
                w.req_type = REQ_W'($urandom_range(REQ_INSERT, REQ_DEL_ALL));
            default:
                w.req_type = REQ_W'($urandom_range(REQ_INSERT, REQ_UNUSED));
        endcase
        if (kind != ROUND_NOISE && $urandom_range(0, 99) < 85) begin
            if (w.req_type == REQ_INSERT)
                w.position = POS_W'($urandom_range(1, len + 1));
            else if (len > 0)
                w.position = POS_W'($urandom_range(1, len));
            else
                w.position = POS_W'($urandom);
        end else begin
            w.position = POS_W'($urandom);
        end
        w.value = pick_value();
        return w;
    endfunction

    // present one request word and hold it until the block takes it
    task automatic send_request(input t_in_word w);
        int gap;
        gap = steady_feed ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        op_count[w.req_type]++;
        sent_count++;
        if (w.req_type == REQ_INSERT) begin
            recent_values[recent_slot] = w.value;
            recent_slot = (recent_slot + 1) % HISTORY;
            if (recent_fill < HISTORY)
                recent_fill++;
        end
    endtask

    // result side: random stalls, sometimes held until a word is waiting, with calm stretches
    initial begin
        int stall;
        int calm_left;
        calm_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (calm_left > 0) begin
                calm_left--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 7) == 0)
                    calm_left = $urandom_range(5, 30);
                stall = $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                if ($urandom_range(0, 1) == 1) begin
                    @(posedge i_clk);
                    while (!o_valid) @(posedge i_clk);
                end
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // reset, directed requests, random rounds, drain and verdict
    initial begin
        t_in_word    opening [$];
        t_round_kind kind;
        int          round_len;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        opening = '{
            // empty list: every error path but a full list, and the harmless no-ops
            make_word(REQ_DEL_MIN, 0, 0),
            make_word(REQ_DELETE, 1, 0),
            make_word(REQ_READ, 0, 0),
            make_word(REQ_REVERSE, 0, 0),
            make_word(REQ_DEL_ALL, 0, 0),
            make_word(REQ_LOCATE, 0, 0),
            make_word(REQ_INSERT, 2, 1),
            make_word(REQ_INSERT, 0, 1),
            make_word(REQ_UNUSED, 31, -1),
            // build min, 5, max, -1, 5 with front, middle and tail inserts
            make_word(REQ_INSERT, 1, 32'sh7FFF_FFFF),
            make_word(REQ_INSERT, 1, 32'sh8000_0000),
            make_word(REQ_INSERT, 3, -1),
            make_word(REQ_INSERT, 2, 5),
            make_word(REQ_INSERT, 5, 5),
            make_word(REQ_READ, 5, 0),
            make_word(REQ_READ, 6, 0),
            make_word(REQ_LOCATE, 0, 5),
            make_word(REQ_LOCATE, 0, 7),
            make_word(REQ_REVERSE, 0, 0),
            // minimum in the last slot, then a tie at the front
            make_word(REQ_DEL_MIN, 0, 0),
            make_word(REQ_INSERT, 1, -1),
            make_word(REQ_DEL_MIN, 0, 0),
            make_word(REQ_DEL_ALL, 0, 5),
            make_word(REQ_DELETE, 2, 0),
            make_word(REQ_DELETE, 1, 0)
        };
        foreach (opening[n])
            send_request(opening[n]);

        // random rounds, each with a bias toward growing, shrinking, mixing or noise
        while (sent_count < ITEM_TARGET) begin
            kind        = t_round_kind'($urandom_range(ROUND_GROW, ROUND_NOISE));
            round_len   = $urandom_range(10, 60);
            steady_feed = ($urandom_range(0, 4) == 0);
            repeat (round_len)
                send_request(make_request(kind, tracked_len));
        end
        i_valid <= 1'b0;

        // let every owed word arrive, then watch a while for strays
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: insert %0d, delete %0d, read %0d, locate %0d, min %0d,",
                 sent_count, op_count[REQ_INSERT], op_count[REQ_DELETE], op_count[REQ_READ],
                 op_count[REQ_LOCATE], op_count[REQ_DEL_MIN]);
        $display("  reverse %0d, remove-all %0d, unused %0d; %0d results checked, %0d errors",
                 op_count[REQ_REVERSE], op_count[REQ_DEL_ALL], op_count[REQ_UNUSED],
                 checked, rejected);
        if (mismatches == 0) begin
            $display("sequential_list_engine_test OK");
        end else begin
            $display("sequential_list_engine_test NOT OK");
        end
        $finish;
    end

endmodule
